/* rtl/rtcp_sr_pkg.sv */
`timescale 1ns / 1ps

package rtcp_sr_pkg;

	// Register file geometry
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_SSRC        = 3'd0;
	localparam logic [IDX_W-1:0] REG_CLOCK_RATE  = 3'd1;
	localparam logic [IDX_W-1:0] REG_FAST_PHASE  = 3'd2;
	localparam logic [IDX_W-1:0] REG_FAST_PERIOD = 3'd3;
	localparam logic [IDX_W-1:0] REG_SLOW_PERIOD = 3'd4;

	// Register reset values
	localparam logic [DATA_W-1:0] RST_SSRC        = 32'd0;
	localparam logic [DATA_W-1:0] RST_CLOCK_RATE  = 32'd90000;
	localparam logic [DATA_W-1:0] RST_FAST_PHASE  = 32'd10000;
	localparam logic [DATA_W-1:0] RST_FAST_PERIOD = 32'd500;
	localparam logic [DATA_W-1:0] RST_SLOW_PERIOD = 32'd4999;

	// Divider: one quotient bit per cycle over a 64-bit quotient
	localparam int QUO_W     = 2 * DATA_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [DATA_W-1:0] sender_ssrc;
		logic [DATA_W-1:0] clock_rate;
		logic [DATA_W-1:0] fast_phase_ms;
		logic [DATA_W-1:0] fast_period_ms;
		logic [DATA_W-1:0] slow_period_ms;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

/* rtl/rtcp_sender_report_generator.sv */
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// in        in_valid / in_ready  payload_bytes, rtp_timestamp, time_ms
// out       out_valid/out_ready  report_valid, report_ssrc, ntp_seconds, ntp_fraction,
//                                report_timestamp, packet_count, octet_count
// config    APB psel/penable     paddr, pwdata, prdata (pready always high)
//
// No report: the transfer, then the output load.
// Report: the transfer, 64 divider steps (one quotient bit each, seconds in the upper
// half, fraction in the lower), a state that sees done, then the load.
// in_ready is high only while idle; a packet may be taken while the previous result
// waits, and the load stalls until the output register is free.
// Reset clears the counters and the last report time and sets the registers to their reset values.

module rtcp_sender_report_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [15:0]                      payload_bytes,
	input  logic [31:0]                      rtp_timestamp,
	input  logic [31:0]                      time_ms,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             report_valid,
	output logic [31:0]                      report_ssrc,
	output logic [31:0]                      ntp_seconds,
	output logic [31:0]                      ntp_fraction,
	output logic [31:0]                      report_timestamp,
	output logic [31:0]                      packet_count,
	output logic [31:0]                      octet_count,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rtcp_sr_pkg::ADDR_W-1:0]   paddr,
	input  logic [rtcp_sr_pkg::DATA_W-1:0]   pwdata,
	output logic [rtcp_sr_pkg::DATA_W-1:0]   prdata,
	output logic                             pready
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_LOAD
	} state_t;

	state_t                         state_q;
	rtcp_sr_pkg::cfg_t              cfg;
	rtcp_sr_pkg::div_status_t       div_st;
	logic [rtcp_sr_pkg::QUO_W-1:0]  div_quo;

	logic [31:0] pkt_cnt_q;
	logic [31:0] oct_cnt_q;
	logic [31:0] last_ms_q;
	logic        due_q;
	logic [31:0] ts_q;
	logic [31:0] pkt_rep_q;
	logic [31:0] oct_rep_q;

	logic        out_valid_q;
	logic        rep_valid_q;
	logic [31:0] rep_ssrc_q;
	logic [31:0] ntp_sec_q;
	logic [31:0] ntp_frac_q;
	logic [31:0] rep_ts_q;
	logic [31:0] pkt_out_q;
	logic [31:0] oct_out_q;

	logic        accept;
	logic [31:0] pkt_next;
	logic [31:0] oct_next;
	logic [31:0] elapsed;
	logic        due;
	logic        out_free;

	rtcp_sr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtcp_sr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && due),
		.dividend (rtp_timestamp),
		.divisor  (cfg.clock_rate),
		.quotient (div_quo),
		.status   (div_st)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Count this packet and test the report schedule
	assign pkt_next = pkt_cnt_q + 32'd1;
	assign oct_next = oct_cnt_q + {16'd0, payload_bytes};
	assign elapsed  = time_ms - last_ms_q;
	assign due      = ((time_ms < cfg.fast_phase_ms) && (elapsed > cfg.fast_period_ms)) ||
	                  (elapsed > cfg.slow_period_ms);

	// Sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pkt_cnt_q   <= '0;
			oct_cnt_q   <= '0;
			last_ms_q   <= '0;
			due_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_LOAD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						due_q <= due;
						if (due) begin
							pkt_cnt_q <= '0;
							oct_cnt_q <= '0;
							last_ms_q <= time_ms;
							state_q   <= S_DIV;
						end else begin
							pkt_cnt_q <= pkt_next;
							oct_cnt_q <= oct_next;
							state_q   <= S_LOAD;
						end
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the report fields of the packet in work
	always_ff @(posedge clk) begin
		if (accept) begin
			ts_q      <= rtp_timestamp;
			pkt_rep_q <= pkt_next;
			oct_rep_q <= oct_next;
		end
	end

	// Load the result; a packet without report gives all zero fields
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && out_free) begin
			rep_valid_q <= due_q;
			rep_ssrc_q  <= due_q ? cfg.sender_ssrc : '0;
			ntp_sec_q   <= due_q ? div_quo[rtcp_sr_pkg::QUO_W-1:rtcp_sr_pkg::DATA_W] : '0;
			ntp_frac_q  <= due_q ? div_quo[rtcp_sr_pkg::DATA_W-1:0] : '0;
			rep_ts_q    <= due_q ? ts_q : '0;
			pkt_out_q   <= due_q ? pkt_rep_q : '0;
			oct_out_q   <= due_q ? oct_rep_q : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign report_valid     = rep_valid_q;
	assign report_ssrc      = rep_ssrc_q;
	assign ntp_seconds      = ntp_sec_q;
	assign ntp_fraction     = ntp_frac_q;
	assign report_timestamp = rep_ts_q;
	assign packet_count     = pkt_out_q;
	assign octet_count      = oct_out_q;

`ifndef ASSERT_OFF
	a_idle_not_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_st.busy)
		else $error("packet taken while divider busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");

	a_no_div_without_report: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !due) |=> !div_st.busy && (state_q == S_LOAD))
		else $error("divider started for a packet without report");

	a_counters_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && due) |=> (pkt_cnt_q == 32'd0) && (oct_cnt_q == 32'd0))
		else $error("counters not cleared after report");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !report_valid) |-> (packet_count == 32'd0) && (ntp_seconds == 32'd0))
		else $error("fields not zero on a result without report");
`endif

endmodule

/* rtl/rtcp_sr_regs.sv */
`timescale 1ns / 1ps

module rtcp_sr_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rtcp_sr_pkg::ADDR_W-1:0]   paddr,
	input  logic [rtcp_sr_pkg::DATA_W-1:0]   pwdata,
	output logic [rtcp_sr_pkg::DATA_W-1:0]   prdata,
	output logic                             pready,
	output rtcp_sr_pkg::cfg_t                cfg
);

	rtcp_sr_pkg::cfg_t            cfg_q;
	logic [rtcp_sr_pkg::IDX_W-1:0] idx;
	logic                          wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[rtcp_sr_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Write registers on the access phase; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sender_ssrc    <= rtcp_sr_pkg::RST_SSRC;
			cfg_q.clock_rate     <= rtcp_sr_pkg::RST_CLOCK_RATE;
			cfg_q.fast_phase_ms  <= rtcp_sr_pkg::RST_FAST_PHASE;
			cfg_q.fast_period_ms <= rtcp_sr_pkg::RST_FAST_PERIOD;
			cfg_q.slow_period_ms <= rtcp_sr_pkg::RST_SLOW_PERIOD;
		end else if (wr_en) begin
			unique case (idx)
				rtcp_sr_pkg::REG_SSRC:        cfg_q.sender_ssrc    <= pwdata;
				rtcp_sr_pkg::REG_CLOCK_RATE:  cfg_q.clock_rate     <= pwdata;
				rtcp_sr_pkg::REG_FAST_PHASE:  cfg_q.fast_phase_ms  <= pwdata;
				rtcp_sr_pkg::REG_FAST_PERIOD: cfg_q.fast_period_ms <= pwdata;
				rtcp_sr_pkg::REG_SLOW_PERIOD: cfg_q.slow_period_ms <= pwdata;
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			rtcp_sr_pkg::REG_SSRC:        prdata = cfg_q.sender_ssrc;
			rtcp_sr_pkg::REG_CLOCK_RATE:  prdata = cfg_q.clock_rate;
			rtcp_sr_pkg::REG_FAST_PHASE:  prdata = cfg_q.fast_phase_ms;
			rtcp_sr_pkg::REG_FAST_PERIOD: prdata = cfg_q.fast_period_ms;
			rtcp_sr_pkg::REG_SLOW_PERIOD: prdata = cfg_q.slow_period_ms;
			default:                      prdata = '0;
		endcase
	end

endmodule

/* rtl/rtcp_sr_div.sv */
`timescale 1ns / 1ps

module rtcp_sr_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rtcp_sr_pkg::DATA_W-1:0]   dividend,
	input  logic [rtcp_sr_pkg::DATA_W-1:0]   divisor,
	output logic [rtcp_sr_pkg::QUO_W-1:0]    quotient,
	output rtcp_sr_pkg::div_status_t         status
);

	logic [rtcp_sr_pkg::QUO_W-1:0]  quo_q;
	logic [rtcp_sr_pkg::DATA_W-1:0] rem_q;
	logic [rtcp_sr_pkg::CNT_W-1:0]  cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [rtcp_sr_pkg::DATA_W:0]   trial;
	logic [rtcp_sr_pkg::DATA_W:0]   diff;
	logic                           fits;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	// A zero divisor always fits, which gives an all-ones quotient.
	assign trial = {rem_q, quo_q[rtcp_sr_pkg::QUO_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	assign quotient = quo_q;
	assign status   = '{busy: busy_q, done: done_q};

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rtcp_sr_pkg::CNT_W'(rtcp_sr_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Advance the datapath; the dividend is the timestamp times 2^32
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {dividend, {rtcp_sr_pkg::DATA_W{1'b0}}};
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[rtcp_sr_pkg::QUO_W-2:0], fits};
			rem_q <= fits ? diff[rtcp_sr_pkg::DATA_W-1:0] : trial[rtcp_sr_pkg::DATA_W-1:0];
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int LIMIT_CYCLES    = 1000000;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int PHASE_COUNT     = 8;
	localparam int DRAIN_CYCLES    = 80;
	localparam int MAX_PAUSE       = 14;

	typedef struct packed {
		logic        due;
		logic [31:0] ssrc;
		logic [31:0] seconds;
		logic [31:0] fraction;
		logic [31:0] timestamp;
		logic [31:0] packets;
		logic [31:0] octets;
	} sender_report_t;

	// Mirror of the generator: registers, counters and the queue of expected results
	class sender_report_scoreboard;
		logic [31:0] ssrc, clock_rate, fast_phase, fast_period, slow_period;
		logic [31:0] packets_pending, octets_pending, last_report_ms;
		sender_report_t expected_reports[$];
		int errors;

		function new();
			ssrc            = rtcp_sr_pkg::RST_SSRC;
			clock_rate      = rtcp_sr_pkg::RST_CLOCK_RATE;
			fast_phase      = rtcp_sr_pkg::RST_FAST_PHASE;
			fast_period     = rtcp_sr_pkg::RST_FAST_PERIOD;
			slow_period     = rtcp_sr_pkg::RST_SLOW_PERIOD;
			packets_pending = '0;
			octets_pending  = '0;
			last_report_ms  = '0;
			errors          = 0;
		endfunction

		function void write_reg(logic [rtcp_sr_pkg::IDX_W-1:0] idx, logic [31:0] value);
			case (idx)
				rtcp_sr_pkg::REG_SSRC:        ssrc = value;
				rtcp_sr_pkg::REG_CLOCK_RATE:  clock_rate = value;
				rtcp_sr_pkg::REG_FAST_PHASE:  fast_phase = value;
				rtcp_sr_pkg::REG_FAST_PERIOD: fast_period = value;
				rtcp_sr_pkg::REG_SLOW_PERIOD: slow_period = value;
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [rtcp_sr_pkg::IDX_W-1:0] idx);
			case (idx)
				rtcp_sr_pkg::REG_SSRC:        return ssrc;
				rtcp_sr_pkg::REG_CLOCK_RATE:  return clock_rate;
				rtcp_sr_pkg::REG_FAST_PHASE:  return fast_phase;
				rtcp_sr_pkg::REG_FAST_PERIOD: return fast_period;
				default:                      return slow_period;
			endcase
		endfunction

		// Count the packet, decide whether a report is due and queue the result
		function void note_packet(logic [15:0] bytes, logic [31:0] ts, logic [31:0] now);
			sender_report_t rpt;
			logic [31:0] elapsed;
			logic [63:0] scaled_rem;
			logic [63:0] quotient;
			rpt = '0;
			packets_pending = packets_pending + 32'd1;
			octets_pending  = octets_pending + {16'd0, bytes};
			elapsed = now - last_report_ms;
			if ((now < fast_phase && elapsed > fast_period) || elapsed > slow_period) begin
				rpt.due       = 1'b1;
				rpt.ssrc      = ssrc;
				rpt.timestamp = ts;
				rpt.packets   = packets_pending;
				rpt.octets    = octets_pending;
				if (clock_rate == '0) begin
					// divider by zero answers all ones
					rpt.seconds  = '1;
					rpt.fraction = '1;
				end else begin
					rpt.seconds = ts / clock_rate;
					scaled_rem  = {ts % clock_rate, 32'd0};
					quotient    = scaled_rem / {32'd0, clock_rate};
					rpt.fraction = quotient[31:0];
				end
				packets_pending = '0;
				octets_pending  = '0;
				last_report_ms  = now;
			end
			expected_reports.push_back(rpt);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compare a transferred result with the oldest expectation
		function void check_report(sender_report_t got);
			sender_report_t want;
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			compare_field("report_valid", {31'd0, want.due}, {31'd0, got.due});
			compare_field("report_ssrc", want.ssrc, got.ssrc);
			compare_field("ntp_seconds", want.seconds, got.seconds);
			compare_field("ntp_fraction", want.fraction, got.fraction);
			compare_field("report_timestamp", want.timestamp, got.timestamp);
			compare_field("packet_count", want.packets, got.packets);
			compare_field("octet_count", want.octets, got.octets);
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic [15:0]                    payload_bytes;
	logic [31:0]                    rtp_timestamp;
	logic [31:0]                    time_ms;
	logic                           out_valid;
	logic                           out_ready;
	logic                           report_valid;
	logic [31:0]                    report_ssrc;
	logic [31:0]                    ntp_seconds;
	logic [31:0]                    ntp_fraction;
	logic [31:0]                    report_timestamp;
	logic [31:0]                    packet_count;
	logic [31:0]                    octet_count;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [rtcp_sr_pkg::ADDR_W-1:0] paddr;
	logic [rtcp_sr_pkg::DATA_W-1:0] pwdata;
	logic [rtcp_sr_pkg::DATA_W-1:0] prdata;
	logic                           pready;

	sender_report_scoreboard sb = new();
	sender_report_t          observed;
	logic                    steady;
	logic [31:0]             stream_ms;
	int                      cycles;

	rtcp_sender_report_generator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.payload_bytes(payload_bytes),
		.rtp_timestamp(rtp_timestamp),
		.time_ms(time_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.report_valid(report_valid),
		.report_ssrc(report_ssrc),
		.ntp_seconds(ntp_seconds),
		.ntp_fraction(ntp_fraction),
		.report_timestamp(report_timestamp),
		.packet_count(packet_count),
		.octet_count(octet_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			observed.due       = report_valid;
			observed.ssrc      = report_ssrc;
			observed.seconds   = ntp_seconds;
			observed.fraction  = ntp_fraction;
			observed.timestamp = report_timestamp;
			observed.packets   = packet_count;
			observed.octets    = octet_count;
			sb.check_report(observed);
		end
	end

	function int pause_cycles();
		return steady ? 0 : $urandom_range(0, MAX_PAUSE);
	endfunction

	// Result side: stall a random number of cycles, then hold ready until a transfer
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pause_cycles();
			if (stall > 0) begin
				@(negedge clk);
				out_ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Present one packet after a random gap and hold it until the transfer
	task automatic send_packet(logic [15:0] bytes, logic [31:0] ts, logic [31:0] now);
		int gap;
		gap = pause_cycles();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      = 1'b1;
		payload_bytes = bytes;
		rtp_timestamp = ts;
		time_ms       = now;
		do @(posedge clk); while (!in_ready);
		sb.note_packet(bytes, ts, now);
	endtask

	// Drop valid and wait until every queued result has been taken
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_reports.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(logic [rtcp_sr_pkg::IDX_W-1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Read back every register and compare with the mirror
	task automatic check_registers();
		for (int k = rtcp_sr_pkg::REG_SSRC; k <= rtcp_sr_pkg::REG_SLOW_PERIOD; k++) begin
			@(negedge clk);
			psel    = 1'b1;
			penable = 1'b0;
			pwrite  = 1'b0;
			paddr   = {rtcp_sr_pkg::IDX_W'(k), 2'b00};
			@(negedge clk);
			penable = 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata !== sb.reg_value(rtcp_sr_pkg::IDX_W'(k))) begin
				$display("%0t: register %0d readback, expected %h, actual %h",
					$time, k, sb.reg_value(rtcp_sr_pkg::IDX_W'(k)), prdata);
				sb.errors++;
			end
			@(negedge clk);
			psel    = 1'b0;
			penable = 1'b0;
		end
	endtask

	// One random packet: time mostly advances in small steps, sometimes jumps or wraps
	task automatic send_random_packet();
		int pick;
		logic [15:0] bytes;
		logic [31:0] ts;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			stream_ms = stream_ms + $urandom_range(0, 400);
		else if (pick < 95)
			stream_ms = stream_ms + $urandom_range(0, 8000);
		else
			stream_ms = $urandom;
		case ($urandom_range(0, 3))
			0: bytes = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			1: bytes = 16'($urandom_range(0, 1500));
			default: bytes = 16'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: ts = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			1: ts = $urandom_range(0, 1000000);
			default: ts = $urandom;
		endcase
		send_packet(bytes, ts, stream_ms);
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		payload_bytes = '0;
		rtp_timestamp = '0;
		time_ms       = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		steady        = 1'b0;
		stream_ms     = '0;
		cycles        = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values, then directed packets around the fast and slow thresholds
		check_registers();
		send_packet(16'h0000, 32'h0000_0000, 32'd0);
		send_packet(16'hFFFF, 32'hFFFF_FFFF, 32'd501);
		send_packet(16'h0001, 32'd90000, 32'd1001);
		send_packet(16'h5555, 32'hAAAA_AAAA, 32'd1002);
		send_packet(16'hAAAA, 32'h5555_5555, 32'd9999);
		send_packet(16'h8000, 32'd89999, 32'd10000);
		send_packet(16'd100, 32'd90001, 32'd14998);
		send_packet(16'd200, 32'd180000, 32'd14999);
		send_packet(16'd300, 32'd1, 32'hFFFF_FFFF);
		// time wraps back to the start of the fast phase
		send_packet(16'd400, 32'd2, 32'd5);
		send_packet(16'd500, 32'd3, 32'd507);
		send_packet(16'd0, 32'h8000_0000, 32'd508);
		drain_results();

		// Zero clock rate, then writes past the register list that must be ignored
		apb_write(rtcp_sr_pkg::REG_CLOCK_RATE, 32'd0);
		send_packet(16'd7, 32'd12345, 32'd20000);
		send_packet(16'd9, 32'hFFFF_FFFF, 32'd30000);
		drain_results();
		for (int k = rtcp_sr_pkg::REG_SLOW_PERIOD + 1; k < (1 << rtcp_sr_pkg::IDX_W); k++)
			apb_write(rtcp_sr_pkg::IDX_W'(k), $urandom);
		check_registers();
		stream_ms = 32'd30000;

		// Random phases, each under its own register setting
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin
					apb_write(rtcp_sr_pkg::REG_SSRC, 32'hFFFF_FFFF);
					apb_write(rtcp_sr_pkg::REG_CLOCK_RATE, 32'd1);
					apb_write(rtcp_sr_pkg::REG_FAST_PHASE, 32'hFFFF_FFFF);
					apb_write(rtcp_sr_pkg::REG_FAST_PERIOD, 32'd0);
					apb_write(rtcp_sr_pkg::REG_SLOW_PERIOD, 32'hFFFF_FFFF);
				end
				1: begin
					apb_write(rtcp_sr_pkg::REG_SSRC, 32'd0);
					apb_write(rtcp_sr_pkg::REG_CLOCK_RATE, 32'hFFFF_FFFF);
					apb_write(rtcp_sr_pkg::REG_FAST_PHASE, 32'd0);
					apb_write(rtcp_sr_pkg::REG_FAST_PERIOD, 32'hFFFF_FFFF);
					apb_write(rtcp_sr_pkg::REG_SLOW_PERIOD, 32'd0);
				end
				2: begin
					apb_write(rtcp_sr_pkg::REG_SSRC, $urandom);
					apb_write(rtcp_sr_pkg::REG_CLOCK_RATE, 32'd0);
					apb_write(rtcp_sr_pkg::REG_FAST_PHASE, $urandom_range(0, 5000));
					apb_write(rtcp_sr_pkg::REG_FAST_PERIOD, 32'd50);
					apb_write(rtcp_sr_pkg::REG_SLOW_PERIOD, 32'd300);
				end
				3: begin
					apb_write(rtcp_sr_pkg::REG_SSRC, $urandom);
					apb_write(rtcp_sr_pkg::REG_CLOCK_RATE, rtcp_sr_pkg::RST_CLOCK_RATE);
					apb_write(rtcp_sr_pkg::REG_FAST_PHASE, rtcp_sr_pkg::RST_FAST_PHASE);
					apb_write(rtcp_sr_pkg::REG_FAST_PERIOD, rtcp_sr_pkg::RST_FAST_PERIOD);
					apb_write(rtcp_sr_pkg::REG_SLOW_PERIOD, rtcp_sr_pkg::RST_SLOW_PERIOD);
				end
				PHASE_COUNT - 1: begin
					apb_write(rtcp_sr_pkg::REG_SSRC, $urandom);
					apb_write(rtcp_sr_pkg::REG_CLOCK_RATE, $urandom);
					apb_write(rtcp_sr_pkg::REG_FAST_PHASE, $urandom);
					apb_write(rtcp_sr_pkg::REG_FAST_PERIOD, $urandom);
					apb_write(rtcp_sr_pkg::REG_SLOW_PERIOD, $urandom);
				end
				default: begin
					apb_write(rtcp_sr_pkg::REG_SSRC, $urandom);
					apb_write(rtcp_sr_pkg::REG_CLOCK_RATE, $urandom_range(1, 200000));
					apb_write(rtcp_sr_pkg::REG_FAST_PHASE, $urandom_range(0, 20000));
					apb_write(rtcp_sr_pkg::REG_FAST_PERIOD, $urandom_range(0, 1000));
					apb_write(rtcp_sr_pkg::REG_SLOW_PERIOD, $urandom_range(0, 6000));
				end
			endcase
			check_registers();
			// restart the time base now and then so the fast phase is revisited
			if ($urandom_range(0, 1))
				stream_ms = $urandom_range(0, 3000);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 40 == 0)
					steady = ($urandom_range(0, 3) == 0);
				send_random_packet();
			end
			drain_results();
		end

		// Let any stray result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_reports.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
